[rtl/pdv_pkg.sv]
package pdv_pkg;

  // fixed-point format
  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned NdcWW    = 17;
  // dividend magnitude width (|a| << FracBits)
  localparam int unsigned NumW     = DataW + FracBits;
  // quotient bits retired per pipeline stage
  localparam int unsigned BitsPerStg = 4;
  localparam int unsigned NumStg     = (NumW + BitsPerStg - 1) / BitsPerStg;
  localparam int unsigned IterW      = NumStg * BitsPerStg;

  localparam logic [NdcWW-1:0] UnitW = NdcWW'(64'(1) << FracBits);

  typedef struct packed {
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] pos_z;
    logic signed [DataW-1:0] pos_w;
  } vtx_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] ndc_x;
    logic signed [DataW-1:0] ndc_y;
    logic signed [DataW-1:0] ndc_z;
    logic [NdcWW-1:0]        ndc_w;
    logic                    saturated;
  } vtx_out_t;

  // per-lane divider state: partial remainder, dividend shift register, sign flag
  typedef struct packed {
    logic [DataW:0]   rem;
    logic [IterW-1:0] num;
    logic             neg;
  } lane_t;

endpackage

[rtl/pdv_if.sv]
interface pdv_in_if;
  import pdv_pkg::*;
  logic    valid;
  logic    ready;
  vtx_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdv_out_if;
  import pdv_pkg::*;
  logic     valid;
  logic     ready;
  vtx_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/perspective_divide_vertex.sv]
// perspective divide of one clip-space vertex position per item
// channels: in_if carries pos_x/y/z/w (signed Q16.16), out_if carries
// ndc_x/y/z (signed Q16.16), ndc_w (1.0 or 0) and a saturated flag.
// both use valid/ready; an item moves when valid and ready are high.
// throughput: one item per cycle while the receiver does not stall.
// structure: the entry stage loads at the accepting edge, then twelve
// restoring divider stages retiring four quotient bits each, then one
// output stage.
// w zero or negative gives an all-zero result.
// when the receiver stalls the whole pipeline holds in place; ready to
// the sender follows output ready, so nothing is lost or repeated.
// reset clears all valid bits; payload registers are not reset.
// the three quotients use three parallel divider lanes sharing the
// divisor held in each stage.
module perspective_divide_vertex (
  input logic clk_i,
  input logic rst_ni,
  pdv_in_if.sink    in_if,
  pdv_out_if.source out_if
);
  import pdv_pkg::*;

  localparam int unsigned Depth = NumStg + 1;

  logic adv;

  // stage registers; index 0 is entry stage
  logic                 vld_q   [Depth];
  lane_t                lane_q  [Depth][3];
  logic [DataW-1:0]     div_q   [Depth];
  logic                 wpos_q  [Depth];
  vtx_out_t             out_q;
  logic                 out_vld_q;

  assign adv         = out_if.ready || !out_vld_q;
  assign in_if.ready = adv;

  // entry: magnitudes and signs
  lane_t             lane_d0 [3];
  logic signed [DataW-1:0] src [3];
  assign src[0] = in_if.data.pos_x;
  assign src[1] = in_if.data.pos_y;
  assign src[2] = in_if.data.pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_d0[i].rem = '0;
      lane_d0[i].neg = src[i][DataW-1];
      lane_d0[i].num = IterW'({(src[i][DataW-1] ? (~src[i] + DataW'(1)) : src[i]),
                                {FracBits{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Depth; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_if.valid;
      for (int s = 1; s < Depth; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) lane_q[0][i] <= lane_d0[i];
      div_q[0]  <= in_if.data.pos_w;
      wpos_q[0] <= !in_if.data.pos_w[DataW-1] && (in_if.data.pos_w != '0);
    end
  end

  // divider stages: BitsPerStg restoring steps each
  for (genvar s = 1; s < Depth; s++) begin : g_stg
    lane_t nxt [3];
    always_comb begin
      logic [DataW:0]   r;
      logic [DataW+1:0] t;
      logic [IterW-1:0] n;
      for (int i = 0; i < 3; i++) begin
        r = lane_q[s-1][i].rem;
        n = lane_q[s-1][i].num;
        for (int b = 0; b < BitsPerStg; b++) begin
          t = {r, n[IterW-1]} - {2'b00, div_q[s-1]};
          n = {n[IterW-2:0], 1'b0};
          if (!t[DataW+1]) begin
            r = t[DataW:0];
            n[0] = 1'b1;
          end else begin
            r = {r[DataW-1:0], lane_q[s-1][i].num[IterW-1-b]};
          end
        end
        nxt[i].rem = r;
        nxt[i].num = n;
        nxt[i].neg = lane_q[s-1][i].neg;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) lane_q[s][i] <= nxt[i];
        div_q[s]  <= div_q[s-1];
        wpos_q[s] <= wpos_q[s-1];
      end
    end
  end

  // sign, saturation and result register
  logic [DataW-1:0] q_res [3];
  logic [2:0]       q_sat;
  always_comb begin
    logic [IterW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag = lane_q[Depth-1][i].num;
      if (lane_q[Depth-1][i].neg) begin
        q_sat[i] = mag > IterW'(64'h8000_0000);
        q_res[i] = q_sat[i] ? DataW'(32'h8000_0000) : (~mag[DataW-1:0] + DataW'(1));
      end else begin
        q_sat[i] = mag > IterW'(64'h7FFF_FFFF);
        q_res[i] = q_sat[i] ? DataW'(32'h7FFF_FFFF) : mag[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wpos_q[Depth-1]) begin
        out_q.ndc_x     <= q_res[0];
        out_q.ndc_y     <= q_res[1];
        out_q.ndc_z     <= q_res[2];
        out_q.ndc_w     <= UnitW;
        out_q.saturated <= |q_sat;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("output changed under stall");
  a_ready_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.ready |-> in_if.ready)
    else $error("input blocked while output free");
  a_w_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.data.ndc_w == UnitW || out_if.data == '0))
    else $error("bad ndc_w");
  a_zero_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.ndc_w == '0 |-> !out_if.data.saturated)
    else $error("saturation on rejected vertex");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import pdv_pkg::*;

  localparam int Latency   = NumStg + 2;
  localparam int MaxCycles = 400000;

  logic clk_i;
  logic rst_ni;

  pdv_in_if  in_if ();
  pdv_out_if out_if ();

  perspective_divide_vertex dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  vtx_in_t  pending_vtx[$];
  vtx_out_t expected_ndc[$];
  int       errors = 0;
  int       cycles = 0;
  int       drv_gap = 0;
  int       mon_gap = 0;
  bit       hold_send = 1'b0;
  bit       stim_done = 1'b0;

  // fixed-point quotient, truncated toward zero and clamped
  function automatic logic [DataW-1:0] fx_quot(input logic signed [DataW-1:0] a,
                                               input logic signed [DataW-1:0] w,
                                               inout bit sat);
    longint num;
    longint q;
    num = longint'(a) * (longint'(1) << FracBits);
    q   = num / longint'(w);
    if (q > 64'sd2147483647) begin
      q   = 64'sd2147483647;
      sat = 1'b1;
    end else if (q < -64'sd2147483648) begin
      q   = -64'sd2147483648;
      sat = 1'b1;
    end
    return q[DataW-1:0];
  endfunction

  // expected ndc position of one vertex
  function automatic vtx_out_t divide_vertex(input vtx_in_t v);
    vtx_out_t r;
    bit       sat;
    sat = 1'b0;
    r   = '0;
    if (v.pos_w > 0) begin
      r.ndc_x     = fx_quot(v.pos_x, v.pos_w, sat);
      r.ndc_y     = fx_quot(v.pos_y, v.pos_w, sat);
      r.ndc_z     = fx_quot(v.pos_z, v.pos_w, sat);
      r.ndc_w     = NdcWW'(64'(1) << FracBits);
      r.saturated = sat;
    end
    return r;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(99) < 60) return 0;
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // coordinate with a mix of extremes, small values and full random
  function automatic logic [DataW-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'($signed($urandom_range(131072)) - 65536);
      3:       return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_w();
    case ($urandom_range(9))
      0:       return 32'($urandom_range(3));
      1:       return 32'(-$signed($urandom_range(100)));
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'($urandom_range(131072, 1));
      5:       return $urandom;
      default: return 32'($urandom_range(32'h0100_0000, 32'h0000_4000));
    endcase
  endfunction

  task automatic add_vtx(input logic [DataW-1:0] x, input logic [DataW-1:0] y,
                         input logic [DataW-1:0] z, input logic [DataW-1:0] w);
    vtx_in_t v;
    v.pos_x = x;
    v.pos_y = y;
    v.pos_z = z;
    v.pos_w = w;
    pending_vtx.push_back(v);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      drv_gap     = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_ndc.push_back(divide_vertex(in_if.data));
      end
      if (!in_if.valid || in_if.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_vtx.size() > 0 && !hold_send) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_vtx.pop_front();
          drv_gap     = rand_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    vtx_out_t exp_r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      mon_gap      = 0;
    end else begin
      cycles++;
      if (out_if.valid && out_if.ready) begin
        if (expected_ndc.size() == 0) begin
          $display("%0t: unexpected item %h", $time, out_if.data);
          errors++;
        end else begin
          exp_r = expected_ndc.pop_front();
          if (out_if.data.ndc_x !== exp_r.ndc_x) begin
            $display("%0t: ndc_x expected %h actual %h", $time, exp_r.ndc_x,
                     out_if.data.ndc_x);
            errors++;
          end
          if (out_if.data.ndc_y !== exp_r.ndc_y) begin
            $display("%0t: ndc_y expected %h actual %h", $time, exp_r.ndc_y,
                     out_if.data.ndc_y);
            errors++;
          end
          if (out_if.data.ndc_z !== exp_r.ndc_z) begin
            $display("%0t: ndc_z expected %h actual %h", $time, exp_r.ndc_z,
                     out_if.data.ndc_z);
            errors++;
          end
          if (out_if.data.ndc_w !== exp_r.ndc_w) begin
            $display("%0t: ndc_w expected %h actual %h", $time, exp_r.ndc_w,
                     out_if.data.ndc_w);
            errors++;
          end
          if (out_if.data.saturated !== exp_r.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_r.saturated, out_if.data.saturated);
            errors++;
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (cycles % 300 > 150) mon_gap = rand_gap();
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycles > MaxCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, w zero/negative, unit w, saturation
    add_vtx(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'h0001_0000);
    add_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000);
    add_vtx(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000);
    add_vtx(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_ffff);
    add_vtx(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
    add_vtx(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
    add_vtx(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h0000_8000);
    add_vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
    add_vtx(32'h4000_0000, 32'hc000_0000, 32'h0000_ffff, 32'h0000_0002);
    add_vtx(32'h0000_0003, 32'hffff_fffd, 32'h1234_5678, 32'h0003_0000);
    add_vtx(32'h7fff_ffff, 32'h8000_0001, 32'h0000_0000, 32'h0001_0001);
    add_vtx(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff);

    // random triangles, three vertices each
    for (int t = 0; t < 214; t++) begin
      for (int k = 0; k < 3; k++) begin
        add_vtx(rand_coord(), rand_coord(), rand_coord(), rand_w());
      end
      // pause the sender once until the pipeline drains
      if (t == 100) begin
        wait (pending_vtx.size() == 0);
        @(posedge clk_i);
        hold_send = 1'b1;
        wait (!in_if.valid && expected_ndc.size() == 0);
        hold_send = 1'b0;
      end
    end

    wait (pending_vtx.size() == 0 && !in_if.valid);
    wait (expected_ndc.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
    if (errors == 0 && expected_ndc.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pdv_pkg.sv
rtl/pdv_if.sv
rtl/perspective_divide_vertex.sv
dv/tb_top.sv
